[src/pmw_pkg.sv]
// Shared constants, codes, state type and helpers for the MST weight unit.
package pmw_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int CNT_W     = NODE_W + 1;
  localparam int CFG_W     = 7;
  localparam int WGT_W     = 32;
  localparam int SUM_W     = 40;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_WR2,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK
  } state_t;

  function automatic logic [CNT_W-1:0] active_nodes(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    n = CNT_W'(cfg);
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (CNT_W'(cfg) > CNT_W'(MAX_NODES)) begin
      n = CNT_W'(MAX_NODES);
    end
    return n;
  endfunction

endpackage

[src/prim_mst_weight_unit.sv]
// Top level: edge store, Prim sequencer over a shared compare pipeline, result register.
//
// Channel  Ports                                          Transfer
// input    start, busy, in_operation, in_node_a,          start && !busy
//          in_node_b, in_edge_weight
// result   out_valid, out_tree_weight, out_reached_nodes  out_valid, one cycle
// config   cfg_we, cfg_wdata                              cfg_we
//
// Add: a dropped edge is skipped; else read, compare, two mirrored writes.
// Clear: one edge-store entry per cycle, over all 4096 entries.
// Compute: each round sweeps one row of the weight memory through its single read port.
// Reset starts a clearing pass over all 4096 entries; busy stays high until it ends.
// The receiver cannot stall: each result shows for one cycle on out_valid.
module prim_mst_weight_unit
  import pmw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic [NODE_W-1:0]       in_node_a,
  input  logic [NODE_W-1:0]       in_node_b,
  input  logic signed [WGT_W-1:0] in_edge_weight,
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] out_tree_weight,
  output logic [CNT_W-1:0]        out_reached_nodes,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]        node_count_r;
  logic [CNT_W-1:0]        n_act;

  logic [ADDR_W-1:0]       clr_r, clr_nxt;
  logic [NODE_W-1:0]       a_r, a_nxt, b_r, b_nxt;
  logic signed [WGT_W-1:0] w_r, w_nxt;

  logic [NODE_W-1:0]       src_r, src_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic [MAX_NODES-1:0]    in_tree_r, in_tree_nxt;
  logic [MAX_NODES-1:0]    key_vld_r, key_vld_nxt;

  logic                    p1_vld_r, p1_vld_nxt;
  logic [NODE_W-1:0]       p1_u_r, p1_u_nxt;
  logic                    p2_vld_r, p2_vld_nxt;
  logic [NODE_W-1:0]       p2_u_r, p2_u_nxt;
  logic signed [WGT_W-1:0] p2_key_r, p2_key_nxt;

  logic                    min_found_r, min_found_nxt;
  logic [NODE_W-1:0]       min_u_r, min_u_nxt;
  logic signed [WGT_W-1:0] min_key_r, min_key_nxt;

  logic signed [SUM_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]        reached_r, reached_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_tw_r, out_tw_nxt;
  logic [CNT_W-1:0]        out_rn_r, out_rn_nxt;

  logic signed [WGT_W-1:0] wgt_mem [0:MAX_NODES*MAX_NODES-1];
  logic                    pres_mem [0:MAX_NODES*MAX_NODES-1];
  logic signed [WGT_W-1:0] key_mem [0:MAX_NODES-1];

  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    wgt_we, pres_we, pres_wdata;
  logic signed [WGT_W-1:0] wgt_rd_r, key_rd_r;
  logic                    pres_rd_r;

  logic                    p1_it, p1_kv, upd, cand, take, drop;
  logic signed [WGT_W-1:0] new_key;

  assign n_act = active_nodes(node_count_r);
  assign busy  = (state_r != ST_IDLE);

  assign rd_addr = (state_r == ST_SCAN) ? {src_r, iss_r[NODE_W-1:0]}
                                        : {in_node_a, in_node_b};

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wr_addr] <= w_r;
    end
    if (pres_we) begin
      pres_mem[wr_addr] <= pres_wdata;
    end
    wgt_rd_r  <= wgt_mem[rd_addr];
    pres_rd_r <= pres_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      key_mem[p1_u_r] <= wgt_rd_r;
    end
    key_rd_r <= key_mem[iss_r[NODE_W-1:0]];
  end

  // shared compare pipeline: relax one neighbor, then fold it into the running minimum
  always_comb begin
    p1_it   = in_tree_r[p1_u_r];
    p1_kv   = key_vld_r[p1_u_r];
    upd     = p1_vld_r && !p1_it && pres_rd_r && (!p1_kv || (wgt_rd_r < key_rd_r));
    cand    = p1_vld_r && !p1_it && (p1_kv || upd);
    new_key = upd ? wgt_rd_r : key_rd_r;
    take    = p2_vld_r && (!min_found_r || (p2_key_r < min_key_r));
    drop    = (in_node_a == in_node_b) || (CNT_W'(in_node_a) >= n_act) ||
              (CNT_W'(in_node_b) >= n_act);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    w_nxt         = w_r;
    src_nxt       = src_r;
    iss_nxt       = iss_r;
    in_tree_nxt   = in_tree_r;
    key_vld_nxt   = key_vld_r;
    p1_vld_nxt    = 1'b0;
    p1_u_nxt      = iss_r[NODE_W-1:0];
    p2_vld_nxt    = cand;
    p2_u_nxt      = p1_u_r;
    p2_key_nxt    = new_key;
    min_found_nxt = min_found_r;
    min_u_nxt     = min_u_r;
    min_key_nxt   = min_key_r;
    total_nxt     = total_r;
    reached_nxt   = reached_r;
    out_valid_nxt = 1'b0;
    out_tw_nxt    = out_tw_r;
    out_rn_nxt    = out_rn_r;
    wgt_we        = 1'b0;
    pres_we       = 1'b0;
    pres_wdata    = 1'b1;
    wr_addr       = {a_r, b_r};

    if (upd) begin
      key_vld_nxt[p1_u_r] = 1'b1;
    end
    if (take) begin
      min_found_nxt = 1'b1;
      min_u_nxt     = p2_u_r;
      min_key_nxt   = p2_key_r;
    end

    case (state_r)
      ST_CLR: begin
        pres_we    = 1'b1;
        pres_wdata = 1'b0;
        wr_addr    = clr_r;
        clr_nxt    = clr_r + ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          a_nxt = in_node_a;
          b_nxt = in_node_b;
          w_nxt = in_edge_weight;
          case (in_operation)
            OP_ADD: begin
              if (!drop) begin
                state_nxt = ST_ADD_CMP;
              end
            end
            OP_TREE: begin
              in_tree_nxt   = {{(MAX_NODES-1){1'b0}}, 1'b1};
              key_vld_nxt   = '0;
              src_nxt       = '0;
              iss_nxt       = '0;
              min_found_nxt = 1'b0;
              total_nxt     = '0;
              reached_nxt   = CNT_W'(1);
              state_nxt     = ST_SCAN;
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_CMP: begin
        if (!pres_rd_r || (w_r < wgt_rd_r)) begin
          wgt_we    = 1'b1;
          pres_we   = 1'b1;
          wr_addr   = {a_r, b_r};
          state_nxt = ST_ADD_WR2;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_WR2: begin
        wgt_we    = 1'b1;
        pres_we   = 1'b1;
        wr_addr   = {b_r, a_r};
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        p1_vld_nxt = 1'b1;
        iss_nxt    = iss_r + CNT_W'(1);
        if ((iss_r + CNT_W'(1)) == n_act) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (min_found_r) begin
          in_tree_nxt[min_u_r] = 1'b1;
          reached_nxt          = reached_r + CNT_W'(1);
          total_nxt            = total_r + {{(SUM_W-WGT_W){min_key_r[WGT_W-1]}}, min_key_r};
          src_nxt              = min_u_r;
          iss_nxt              = '0;
          min_found_nxt        = 1'b0;
          state_nxt            = ST_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          out_tw_nxt    = total_r;
          out_rn_nxt    = reached_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      node_count_r <= CFG_W'(MAX_NODES);
      in_tree_r    <= '0;
      key_vld_r    <= '0;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      min_found_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      in_tree_r   <= in_tree_nxt;
      key_vld_r   <= key_vld_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p2_vld_nxt;
      min_found_r <= min_found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    w_r       <= w_nxt;
    src_r     <= src_nxt;
    iss_r     <= iss_nxt;
    p1_u_r    <= p1_u_nxt;
    p2_u_r    <= p2_u_nxt;
    p2_key_r  <= p2_key_nxt;
    min_u_r   <= min_u_nxt;
    min_key_r <= min_key_nxt;
    total_r   <= total_nxt;
    reached_r <= reached_nxt;
    out_tw_r  <= out_tw_nxt;
    out_rn_r  <= out_rn_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_tree_weight   = out_tw_r;
  assign out_reached_nodes = out_rn_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reached_nodes >= CNT_W'(1)) && (out_reached_nodes <= n_act))
    else $error("reached node count out of range");

  a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) && min_found_r |-> !in_tree_r[min_u_r])
    else $error("picked node already in tree");

  a_pipe_scope: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> (state_r == ST_SCAN) || (state_r == ST_DRAIN))
    else $error("compare pipeline active outside a sweep");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for prim_mst_weight_unit: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pmw_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int PLAN_LEN = 26;

  typedef struct packed {
    logic                    set_count;
    logic [CFG_W-1:0]        count;
    logic [1:0]              op;
    logic [NODE_W-1:0]       a;
    logic [NODE_W-1:0]       b;
    logic signed [WGT_W-1:0] w;
    logic                    typed;
    logic signed [SUM_W-1:0] tw;
    logic [CNT_W-1:0]        nr;
  } plan_row_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] tw;
    logic [CNT_W-1:0]        nr;
  } tree_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, 40'sd0,           7'd1},
    '{1'b0, 7'd0,   OP_NONE,  6'd63, 6'd63, 32'shFFFF_FFFF,  1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd5,  6'd5,  32'sd5,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, 40'sd0,           7'd1},
    '{1'b0, 7'd0,   OP_ADD,   6'd0,  6'd63, 32'sh8000_0000,  1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd63, 6'd0,  32'sh7FFF_FFFF,  1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, -40'sd2147483648, 7'd2},
    '{1'b0, 7'd0,   OP_ADD,   6'd1,  6'd2,  32'sd7,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, -40'sd2147483648, 7'd2},
    '{1'b0, 7'd0,   OP_ADD,   6'd0,  6'd1,  32'sh7FFF_FFFF,  1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd63, 6'd62, 32'sh7FFF_FFFF,  1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd2,  6'd62, 32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd62, 6'd1,  -32'sd1,         1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_CLEAR, 6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, 40'sd0,           7'd1},
    '{1'b1, 7'd2,   OP_ADD,   6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd1,  6'd0,  -32'sd3,         1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd0,  6'd2,  32'sd4,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_ADD,   6'd63, 6'd1,  32'sd1,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, -40'sd3,          7'd2},
    '{1'b1, 7'd0,   OP_ADD,   6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, 40'sd0,           7'd1},
    '{1'b1, 7'd127, OP_ADD,   6'd0,  6'd0,  32'sd0,          1'b0, 40'sd0,           7'd0},
    '{1'b0, 7'd0,   OP_TREE,  6'd0,  6'd0,  32'sd0,          1'b1, -40'sd3,          7'd2}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_operation = OP_ADD;
  logic [NODE_W-1:0]       in_node_a = '0;
  logic [NODE_W-1:0]       in_node_b = '0;
  logic signed [WGT_W-1:0] in_edge_weight = '0;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_tree_weight;
  logic [CNT_W-1:0]        out_reached_nodes;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  logic signed [WGT_W-1:0] edge_wt [MAX_NODES][MAX_NODES];
  bit                      edge_on [MAX_NODES][MAX_NODES];
  logic [CFG_W-1:0]        node_cfg = 7'd64;
  tree_t                   pending_trees [$];
  int                      err_count = 0;
  int                      items_sent = 0;
  int                      idle_cycles = 0;
  int                      burst_left = 0;

  prim_mst_weight_unit u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int nodes_in_use();
    if (node_cfg == '0) return 1;
    if (int'(node_cfg) > MAX_NODES) return MAX_NODES;
    return int'(node_cfg);
  endfunction

  function automatic void load_edge(int a, int b, logic signed [WGT_W-1:0] w);
    if (a == b || a >= nodes_in_use() || b >= nodes_in_use()) return;
    if (!edge_on[a][b] || w < edge_wt[a][b]) begin
      edge_wt[a][b] = w;
      edge_wt[b][a] = w;
      edge_on[a][b] = 1'b1;
      edge_on[b][a] = 1'b1;
    end
  endfunction

  function automatic void wipe_edges();
    foreach (edge_on[i, j]) edge_on[i][j] = 1'b0;
  endfunction

  function automatic tree_t grow_tree();
    bit                      joined [MAX_NODES];
    bit                      keyed [MAX_NODES];
    logic signed [WGT_W-1:0] key [MAX_NODES];
    logic signed [63:0]      acc;
    int                      n;
    int                      v;
    int                      pick;
    int                      reached;
    tree_t                   res;
    n = nodes_in_use();
    joined = '{default: 1'b0};
    keyed = '{default: 1'b0};
    acc = '0;
    reached = 1;
    joined[0] = 1'b1;
    v = 0;
    while (1'b1) begin
      for (int u = 0; u < n; u++) begin
        if (!joined[u] && edge_on[v][u] && (!keyed[u] || edge_wt[v][u] < key[u])) begin
          key[u] = edge_wt[v][u];
          keyed[u] = 1'b1;
        end
      end
      pick = -1;
      for (int u = 0; u < n; u++) begin
        if (!joined[u] && keyed[u] && (pick < 0 || key[u] < key[pick])) pick = u;
      end
      if (pick < 0) break;
      joined[pick] = 1'b1;
      reached++;
      acc += key[pick];
      v = pick;
    end
    res.tw = acc[SUM_W-1:0];
    res.nr = CNT_W'(reached);
    return res;
  endfunction

  function automatic logic signed [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return $urandom;
      4: return -32'sd1;
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  task automatic flag(input string what);
    if (err_count < 10) $display("%0t mismatch: %s", $realtime, what);
    err_count++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_trees.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_nodes(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    node_cfg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic signed [WGT_W-1:0] w,
                           input logic typed, input tree_t given);
    int gap;
    in_operation <= op;
    in_node_a <= a;
    in_node_b <= b;
    in_edge_weight <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    case (op)
      OP_ADD: load_edge(int'(a), int'(b), w);
      OP_TREE: pending_trees.insert(pending_trees.size(), typed ? given : grow_tree());
      OP_CLEAR: wipe_edges();
      default: ;
    endcase
    if (op != OP_NONE) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : check_trees
    tree_t due;
    if (out_valid === 1'b1) begin
      if (pending_trees.size() == 0) begin
        flag($sformatf("unexpected transfer: weight %0d nodes %0d",
                       out_tree_weight, out_reached_nodes));
      end else begin
        due = pending_trees.pop_front();
        if (out_tree_weight !== due.tw || out_reached_nodes !== due.nr) begin
          flag($sformatf("weight exp %0d got %0d, nodes exp %0d got %0d",
                         due.tw, out_tree_weight, due.nr, out_reached_nodes));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int               n;
    int               len;
    int               k;
    int               a;
    int               b;
    logic [CFG_W-1:0] cnt;
    tree_t            none;
    none = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].set_count) begin
        set_nodes(PLAN[i].count);
      end else begin
        send_item(PLAN[i].op, PLAN[i].a, PLAN[i].b, PLAN[i].w, PLAN[i].typed,
                  tree_t'{PLAN[i].tw, PLAN[i].nr});
      end
    end

    while (items_sent < 500) begin
      case ($urandom_range(0, 11))
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd64;
        3: cnt = CFG_W'($urandom_range(65, 127));
        4: cnt = CFG_W'($urandom_range(13, 63));
        default: cnt = CFG_W'($urandom_range(2, 12));
      endcase
      set_nodes(cnt);
      n = nodes_in_use();
      if ($urandom_range(0, 4) == 0) begin
        send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b0, none);
      end
      len = $urandom_range(1, (n < 14) ? 3 * n : 40);
      repeat (len) begin
        k = $urandom_range(0, 15);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if (k == 0) begin
          send_item(OP_NONE, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b0, none);
        end else if (k == 1) begin
          send_item(OP_TREE, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b0, none);
        end else if (k == 2) begin
          send_item(OP_ADD, NODE_W'(a), NODE_W'(a), pick_weight(), 1'b0, none);
        end else if (k == 3) begin
          send_item(OP_ADD, NODE_W'($urandom), NODE_W'($urandom), pick_weight(), 1'b0, none);
        end else begin
          send_item(OP_ADD, NODE_W'(a), NODE_W'(b), pick_weight(), 1'b0, none);
        end
      end
      send_item(OP_TREE, NODE_W'($urandom), NODE_W'($urandom), $urandom, 1'b0, none);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_trees.size() != 0) flag("results still due at end of run");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
